[rtl/bloom_filter_four_hash_defines.svh]
// Assertion helpers shared by the filter RTL.
`ifndef BLOOM_FILTER_FOUR_HASH_DEFINES_SVH
`define BLOOM_FILTER_FOUR_HASH_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define BFF4_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bloom filter check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define BFF4_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bloom filter check failed");

`endif

[rtl/bff4_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bff4_pkg;

   // Filter storage
   localparam int MAX_BITS = 1024;
   localparam int IDX_W    = $clog2(MAX_BITS);
   localparam int MOD_W    = $clog2(MAX_BITS + 1);

   // Field widths
   localparam int CSR_W  = 11;
   localparam int CHAR_W = 8;

   // Reducer operand: sum + character * power
   localparam int OP_W  = CHAR_W + IDX_W + 1;
   localparam int CNT_W = $clog2(OP_W);

   localparam logic [CSR_W-1:0] TABLE_SIZE_RESET = CSR_W'(100);

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   typedef logic [4:0] base_type;
   typedef logic [2:0] offset_type;

   localparam base_type   HASH_BASE   [3] = '{5'd19, 5'd30, 5'd21};
   localparam offset_type HASH_OFFSET [4] = '{3'd0, 3'd1, 3'd7, 3'd3};

endpackage

`default_nettype wire

[rtl/bff4_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface bff4_req_if;
   import bff4_pkg::*;

   logic              valid;
   logic              ready;
   logic              cmd;
   logic [CHAR_W-1:0] character;
   logic              last;

   modport source (output valid, cmd, character, last, input ready);
   modport sink   (input valid, cmd, character, last, output ready);
endinterface

`default_nettype wire

[rtl/bff4_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface bff4_rsp_if;
   logic valid;
   logic ready;
   logic maybe_present;

   modport source (output valid, maybe_present, input ready);
   modport sink   (input valid, maybe_present, output ready);
endinterface

`default_nettype wire

[rtl/bloom_filter_four_hash.sv]
// Operation: a character is accepted, then 7 modular reductions run on the bit-serial
//   unit; the last character adds 4 more reductions, then sets 4 bits (insert) or
//   reads and checks them (query), and a query then posts the answer.
// Throughput: one transaction at a time, bounded by the bit-serial modulo unit.
// Reset: synchronous, active high; a clearing pass then zeroes all MAX_BITS filter
//   bits before the first request transaction is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "bloom_filter_four_hash_defines.svh"

module bloom_filter_four_hash (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wr_en,
   input  wire logic [bff4_pkg::CSR_W-1:0] csr_wr_data,
   bff4_req_if.sink                        req_if,
   bff4_rsp_if.source                      rsp_if
);
   import bff4_pkg::*;

   // Sequencer states
   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_LOAD  = 4'd2;
   localparam logic [3:0] ST_RED   = 4'd3;
   localparam logic [3:0] ST_STORE = 4'd4;
   localparam logic [3:0] ST_INS   = 4'd5;
   localparam logic [3:0] ST_QRD   = 4'd6;
   localparam logic [3:0] ST_QCHK  = 4'd7;
   localparam logic [3:0] ST_RESP  = 4'd8;

   // Reduction steps per character: four sums, three powers; then four indices
   localparam logic [3:0] STEP_SUM0 = 4'd0;
   localparam logic [3:0] STEP_SUM1 = 4'd1;
   localparam logic [3:0] STEP_SUM2 = 4'd2;
   localparam logic [3:0] STEP_SUM3 = 4'd3;
   localparam logic [3:0] STEP_POW0 = 4'd4;
   localparam logic [3:0] STEP_POW1 = 4'd5;
   localparam logic [3:0] STEP_POW2 = 4'd6;
   localparam logic [3:0] STEP_IDX0 = 4'd7;
   localparam logic [3:0] STEP_IDX1 = 4'd8;
   localparam logic [3:0] STEP_IDX2 = 4'd9;
   localparam logic [3:0] STEP_IDX3 = 4'd10;

   typedef logic [IDX_W-1:0] idx_type;

   logic [3:0]        state_ff, state_in;
   logic [3:0]        step_ff, step_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [1:0]        k_ff, k_in;
   idx_type           clr_ff, clr_in;
   idx_type           rem_ff, rem_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic              cmd_ff, cmd_in;
   logic [CHAR_W-1:0] ch_ff, ch_in;
   logic              last_ff, last_in;
   idx_type           sum_ff [4];
   idx_type           sum_in [4];
   idx_type           pow_ff [3];
   idx_type           pow_in [3];
   idx_type           idx_ff [4];
   idx_type           idx_in [4];
   logic              all_ff, all_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_mp_ff, rsp_mp_in;
   logic [CSR_W-1:0]  tsize_ff;

   logic [MOD_W-1:0]  mod_act;
   logic [IDX_W:0]    mod_ext;
   logic [IDX_W:0]    trial;
   idx_type           rem_next;
   logic [CHAR_W-1:0] mul_a;
   idx_type           mul_b;
   logic [OP_W-1:0]   add_c;
   logic [OP_W-1:0]   op_comb;

   logic              ram_wr_en;
   logic              ram_wr_data;
   idx_type           ram_addr;
   logic              ram_rdata;

   // Clamp the configured size to the range 1 .. MAX_BITS
   always_comb begin
      if (tsize_ff == '0) begin
         mod_act = MOD_W'(1);
      end else if (int'(tsize_ff) > MAX_BITS) begin
         mod_act = MOD_W'(MAX_BITS);
      end else begin
         mod_act = MOD_W'(tsize_ff);
      end
   end

   assign mod_ext = (IDX_W + 1)'(mod_act);

   // Restoring modulo: shift in one operand bit, subtract the modulus if it fits
   assign trial    = {rem_ff, op_ff[OP_W-1]};
   assign rem_next = (trial >= mod_ext) ? IDX_W'(trial - mod_ext) : IDX_W'(trial);

   // Operand for the current step: add_c + mul_a * mul_b, one shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      add_c = '0;
      unique case (step_ff)
         STEP_SUM0: begin
            add_c = OP_W'(sum_ff[0]) + OP_W'(ch_ff);
         end
         STEP_SUM1: begin
            mul_a = ch_ff;
            mul_b = pow_ff[0];
            add_c = OP_W'(sum_ff[1]);
         end
         STEP_SUM2: begin
            mul_a = ch_ff;
            mul_b = pow_ff[1];
            add_c = OP_W'(sum_ff[2]);
         end
         STEP_SUM3: begin
            mul_a = ch_ff;
            mul_b = pow_ff[2];
            add_c = OP_W'(sum_ff[3]);
         end
         STEP_POW0: begin
            mul_a = CHAR_W'(HASH_BASE[0]);
            mul_b = pow_ff[0];
         end
         STEP_POW1: begin
            mul_a = CHAR_W'(HASH_BASE[1]);
            mul_b = pow_ff[1];
         end
         STEP_POW2: begin
            mul_a = CHAR_W'(HASH_BASE[2]);
            mul_b = pow_ff[2];
         end
         STEP_IDX0: begin
            add_c = OP_W'(sum_ff[0]) + OP_W'(HASH_OFFSET[0]);
         end
         STEP_IDX1: begin
            add_c = OP_W'(sum_ff[1]) + OP_W'(HASH_OFFSET[1]);
         end
         STEP_IDX2: begin
            add_c = OP_W'(sum_ff[2]) + OP_W'(HASH_OFFSET[2]);
         end
         STEP_IDX3: begin
            add_c = OP_W'(sum_ff[3]) + OP_W'(HASH_OFFSET[3]);
         end
         default: begin
            add_c = '0;
         end
      endcase
   end

   assign op_comb = add_c + OP_W'(mul_a) * OP_W'(mul_b);

   // Filter bit array: cleared by the sweep, set on insert, read on query
   assign ram_wr_en   = (state_ff == ST_CLEAR) || (state_ff == ST_INS);
   assign ram_wr_data = (state_ff == ST_INS);
   assign ram_addr    = (state_ff == ST_CLEAR) ? clr_ff : idx_ff[k_ff];

   bff4_ram #(
      .WIDTH (1),
      .DEPTH (MAX_BITS)
   ) u_filter_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_addr),
      .rd_data (ram_rdata)
   );

   // Take a request only when idle; the result register decouples the response side
   assign req_if.ready         = (state_ff == ST_IDLE);
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.maybe_present = rsp_mp_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      clr_in       = clr_ff;
      rem_in       = rem_ff;
      op_in        = op_ff;
      cmd_in       = cmd_ff;
      ch_in        = ch_ff;
      last_in      = last_ff;
      sum_in       = sum_ff;
      pow_in       = pow_ff;
      idx_in       = idx_ff;
      all_in       = all_ff;
      rsp_mp_in    = rsp_mp_ff;
      rsp_valid_in = rsp_valid_ff;

      // Drop the held result once the consumer takes it
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(MAX_BITS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_if.valid) begin
               cmd_in   = req_if.cmd;
               ch_in    = req_if.character;
               last_in  = req_if.last;
               step_in  = STEP_SUM0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            op_in    = op_comb;
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_RED;
         end
         ST_RED: begin
            op_in  = op_ff << 1;
            rem_in = rem_next;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(OP_W - 1)) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            unique case (step_ff)
               STEP_SUM0: sum_in[0] = rem_ff;
               STEP_SUM1: sum_in[1] = rem_ff;
               STEP_SUM2: sum_in[2] = rem_ff;
               STEP_SUM3: sum_in[3] = rem_ff;
               STEP_POW0: pow_in[0] = rem_ff;
               STEP_POW1: pow_in[1] = rem_ff;
               STEP_POW2: pow_in[2] = rem_ff;
               STEP_IDX0: idx_in[0] = rem_ff;
               STEP_IDX1: idx_in[1] = rem_ff;
               STEP_IDX2: idx_in[2] = rem_ff;
               STEP_IDX3: idx_in[3] = rem_ff;
               default:   idx_in    = idx_ff;
            endcase
            if ((step_ff == STEP_POW2) && !last_ff) begin
               state_in = ST_IDLE;
            end else if (step_ff == STEP_IDX3) begin
               // Name complete: restart the running hashes
               for (int i = 0; i < 4; i++) begin
                  sum_in[i] = '0;
               end
               for (int i = 0; i < 3; i++) begin
                  pow_in[i] = IDX_W'(1);
               end
               k_in     = '0;
               all_in   = 1'b1;
               state_in = (cmd_ff == CMD_INSERT) ? ST_INS : ST_QRD;
            end else begin
               step_in  = step_ff + 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_INS: begin
            k_in = k_ff + 1'b1;
            if (k_ff == 2'd3) begin
               state_in = ST_IDLE;
            end
         end
         ST_QRD: begin
            state_in = ST_QCHK;
         end
         ST_QCHK: begin
            all_in = all_ff & ram_rdata;
            if (k_ff == 2'd3) begin
               state_in = ST_RESP;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_QRD;
            end
         end
         ST_RESP: begin
            // Hold until the result register is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_mp_in    = all_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and hash state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         tsize_ff     <= TABLE_SIZE_RESET;
         for (int i = 0; i < 4; i++) begin
            sum_ff[i] <= '0;
         end
         for (int i = 0; i < 3; i++) begin
            pow_ff[i] <= IDX_W'(1);
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
         pow_ff       <= pow_in;
         if (csr_wr_en) begin
            tsize_ff <= csr_wr_data;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      cnt_ff    <= cnt_in;
      k_ff      <= k_in;
      rem_ff    <= rem_in;
      op_ff     <= op_in;
      cmd_ff    <= cmd_in;
      ch_ff     <= ch_in;
      last_ff   <= last_in;
      idx_ff    <= idx_in;
      all_ff    <= all_in;
      rsp_mp_ff <= rsp_mp_in;
   end

   // Checks
   `BFF4_ASSERT_NEXT(a_accept_starts_work, clock, reset, req_if.valid && req_if.ready, state_ff == ST_LOAD)
   `BFF4_ASSERT_NEXT(a_clear_bit_misses, clock, reset, (state_ff == ST_QCHK) && !ram_rdata, !all_ff)
   `BFF4_ASSERT_IMPL(a_result_from_resp, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_RESP)

endmodule

`default_nettype wire

[rtl/bff4_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module bff4_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire
